// ===== rtl/bfme_pkg.sv =====
`default_nettype none
package bfme_pkg;

    // Number of byte slots in the store.
    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the channels.
    localparam int CAP_W  = 9;
    localparam int WORD_W = 32;
    localparam int FILL_W = 9;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_ONE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_TWO = 2'd1;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_ROOM = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NO_DATA = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XFER,
        ST_DRAIN,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/bfme_in_if.sv =====
`default_nettype none
interface bfme_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bfme_pkg::SIZE_W-1:0]  size_code;
    logic                         big_endian;
    logic [bfme_pkg::WORD_W-1:0]  push_word;

    modport source (output valid, kind, size_code, big_endian, push_word, input ready);
    modport sink   (input valid, kind, size_code, big_endian, push_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfme_out_if.sv =====
`default_nettype none
interface bfme_out_if;
    logic                         valid;
    logic                         ready;
    logic [bfme_pkg::WORD_W-1:0]  pop_word;
    logic [bfme_pkg::STAT_W-1:0]  status;
    logic [bfme_pkg::FILL_W-1:0]  fill_level;

    modport source (output valid, pop_word, status, fill_level, input ready);
    modport sink   (input valid, pop_word, status, fill_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfme_cfg_if.sv =====
`default_nettype none
interface bfme_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bfme_pkg::CAP_W-1:0]  capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfme_ram.sv =====
`default_nettype none
module bfme_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/byte_fifo_multibyte_endian_unit.sv =====
`default_nettype none
// Circular byte FIFO with multi-byte push and pop.
// The input channel carries one operation per transaction: a push or a pop of
// one, two or four bytes, in big- or little-endian byte order. Every input
// transaction yields exactly one output transaction with the popped word (zero
// unless a pop succeeded), a status code and the fill level after the operation.
// The configuration channel writes the capacity; a write empties the FIFO and
// clamps the value to the range one through the store depth. It is always ready
// and must only be used while no operation is in flight.
// Sequencing: a transaction is accepted in the idle state, then the byte mover
// makes one memory access per byte through the byte RAM, one access per cycle;
// a push then goes to the output state, and a pop first passes a drain state for
// the registered read data. A failed operation answers on the next cycle. The
// block takes one operation at a time and accepts no new one until the result
// has been taken and it has returned to idle.
// Reset clears the positions, the fill count and the control state and sets the
// capacity to the full depth; the byte store itself is not cleared. When the
// receiver stalls, the result is held in the output register and no new input
// transaction is accepted until the result has been taken.
module byte_fifo_multibyte_endian_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bfme_in_if.sink   i_in,
    bfme_out_if.source o_out,
    bfme_cfg_if.sink  i_cfg
);
    import bfme_pkg::*;

    t_state r_state, n_state;

    // Operation registers captured at acceptance.
    logic              r_kind;
    logic              r_big;
    logic [1:0]        r_nm1;
    logic [WORD_W-1:0] r_word;
    logic [1:0]        r_step;

    // FIFO state.
    logic [CNT_W-1:0]  r_cap;
    logic [PTR_W-1:0]  r_wr_pos;
    logic [PTR_W-1:0]  r_rd_pos;
    logic [CNT_W-1:0]  r_count;

    // Result registers.
    logic [WORD_W-1:0] r_result;
    logic [STAT_W-1:0] r_status;

    // Read pipeline: lane of the byte that the RAM returns this cycle.
    logic              r_rd_vld;
    logic [1:0]        r_lane_d;

    logic              in_fire;
    logic              out_fire;
    logic              cfg_fire;
    logic [1:0]        in_nm1;
    logic [CNT_W:0]    in_nbytes;
    logic              push_fail;
    logic              pop_fail;
    logic              op_fail;
    logic [1:0]        lane;
    logic              last_step;
    logic [PTR_W-1:0]  cur_pos;
    logic [CNT_W-1:0]  pos_inc;
    logic [PTR_W-1:0]  pos_next;
    logic [7:0]        push_byte;
    logic [7:0]        ram_rdata;
    logic              ram_we;
    logic              ram_re;
    logic              busy_xfer;
    logic [CNT_W-1:0]  cfg_cap;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    // Size code three is handled like four bytes.
    always_comb begin
        case (i_in.size_code)
            SIZE_ONE: in_nm1 = 2'd0;
            SIZE_TWO: in_nm1 = 2'd1;
            default:  in_nm1 = 2'd3;
        endcase
    end

    assign in_nbytes = (CNT_W+1)'(in_nm1) + 1'b1;
    assign push_fail = ({1'b0, r_cap} < ({1'b0, r_count} + in_nbytes));
    assign pop_fail  = ({1'b0, r_count} < in_nbytes);
    assign op_fail   = (i_in.kind == KIND_PUSH) ? push_fail : pop_fail;

    // Shared byte mover: lane select and position advance, one byte per cycle.
    assign lane      = r_big ? (r_nm1 - r_step) : r_step;
    assign last_step = (r_step == r_nm1);
    assign cur_pos   = (r_kind == KIND_PUSH) ? r_wr_pos : r_rd_pos;
    assign pos_inc   = CNT_W'(cur_pos) + 1'b1;
    assign pos_next  = (pos_inc >= r_cap) ? '0 : pos_inc[PTR_W-1:0];

    always_comb begin
        case (lane)
            2'd0:    push_byte = r_word[7:0];
            2'd1:    push_byte = r_word[15:8];
            2'd2:    push_byte = r_word[23:16];
            default: push_byte = r_word[31:24];
        endcase
    end

    // Capacity clamp for a configuration write.
    always_comb begin
        if (i_cfg.capacity == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (32'(i_cfg.capacity) > 32'(DEPTH)) begin
            cfg_cap = CNT_W'(DEPTH);
        end else begin
            cfg_cap = CNT_W'(i_cfg.capacity);
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = op_fail ? ST_OUT : ST_XFER;
                end
            end
            ST_XFER: begin
                if (last_step) begin
                    n_state = (r_kind == KIND_POP) ? ST_DRAIN : ST_OUT;
                end
            end
            ST_DRAIN: n_state = ST_OUT;
            ST_OUT: begin
                if (out_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-decoded outputs.
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        busy_xfer   = 1'b0;
        unique case (r_state)
            ST_IDLE:  i_in.ready  = 1'b1;
            ST_XFER:  busy_xfer   = 1'b1;
            ST_DRAIN: busy_xfer   = 1'b0;
            ST_OUT:   o_out.valid = 1'b1;
            default:  i_in.ready  = 1'b0;
        endcase
    end

    assign i_cfg.ready = 1'b1;
    assign ram_we = busy_xfer && (r_kind == KIND_PUSH);
    assign ram_re = busy_xfer && (r_kind == KIND_POP);

    assign o_out.pop_word   = r_result;
    assign o_out.status     = r_status;
    assign o_out.fill_level = FILL_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cap    <= CNT_W'(DEPTH);
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= ram_re;
            if (cfg_fire) begin
                r_cap    <= cfg_cap;
                r_wr_pos <= '0;
                r_rd_pos <= '0;
                r_count  <= '0;
            end else begin
                if (in_fire && !op_fail) begin
                    if (i_in.kind == KIND_PUSH) begin
                        r_count <= r_count + in_nbytes[CNT_W-1:0];
                    end else begin
                        r_count <= r_count - in_nbytes[CNT_W-1:0];
                    end
                end
                if (ram_we) begin
                    r_wr_pos <= pos_next;
                end
                if (ram_re) begin
                    r_rd_pos <= pos_next;
                end
            end
        end
    end

    // Payload and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind   <= i_in.kind;
            r_big    <= i_in.big_endian;
            r_nm1    <= in_nm1;
            r_word   <= i_in.push_word;
            r_step   <= '0;
            r_result <= '0;
            if (!op_fail) begin
                r_status <= STATUS_OK;
            end else if (i_in.kind == KIND_PUSH) begin
                r_status <= STATUS_NO_ROOM;
            end else begin
                r_status <= STATUS_NO_DATA;
            end
        end else begin
            if (busy_xfer) begin
                r_step <= r_step + 1'b1;
            end
            if (r_rd_vld) begin
                case (r_lane_d)
                    2'd0:    r_result[7:0]   <= ram_rdata;
                    2'd1:    r_result[15:8]  <= ram_rdata;
                    2'd2:    r_result[23:16] <= ram_rdata;
                    default: r_result[31:24] <= ram_rdata;
                endcase
            end
        end
        r_lane_d <= lane;
    end

    bfme_ram #(
        .ADDR_W (PTR_W),
        .DATA_W (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_pos),
        .i_wdata (push_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_pos),
        .o_rdata (ram_rdata)
    );

endmodule
`default_nettype wire
